// File: hw/rtl/json_string_unescape_core_defines.svh
// Assertion macros for the unescape core; clocked on clk, disabled in reset.
`ifndef JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`ifndef SYNTH
`define JSU_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("jsu: implication check failed");
`define JSU_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("jsu: next-cycle check failed");
`else
`define JSU_ASSERT_IMPLY(lbl, pre, post)
`define JSU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/jsu_pkg.sv
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	localparam logic [2:0] ST_BYTE   = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_NOOPEN = 3'd2;
	localparam logic [2:0] ST_BADESC = 3'd3;
	localparam logic [2:0] ST_BADHEX = 3'd4;
	localparam logic [2:0] ST_CTRL   = 3'd5;
	localparam logic [2:0] ST_TRUNC  = 3'd6;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  hex_count;
		logic [11:0] code_partial;
	} scan_state_t;

	// up to three result words from one input word; status is shared
	typedef struct packed {
		logic [1:0] count;
		logic [2:0] status;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} result_t;

endpackage

// File: hw/rtl/jsu_decode.sv
module jsu_decode import jsu_pkg::*; (
	input  scan_state_t cur,
	input  logic [7:0]  in_byte,
	input  logic        text_end,
	output scan_state_t nxt,
	output result_t     res
);

	localparam logic [7:0] Quote = 8'h22;
	localparam logic [7:0] Bslash = 8'h5C;

	logic        is_hex;
	logic [3:0]  digit;
	logic [15:0] cp;
	logic [15:0] cp_f;
	result_t     enc;

	always_comb begin
		is_hex = 1'b1;
		digit = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			digit = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			digit = in_byte[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	// encode the finished code point as UTF-8, surrogates replaced
	always_comb begin
		cp = {cur.code_partial, digit};
		cp_f = (cp[15:11] == 5'b11011) ? 16'hFFFD : cp;
		enc = '0;
		enc.status = ST_BYTE;
		if (cp_f < 16'h0080) begin
			enc.count = 2'd1;
			enc.b0 = cp_f[7:0];
		end else if (cp_f < 16'h0800) begin
			enc.count = 2'd2;
			enc.b0 = 8'hC0 | {3'b000, cp_f[10:6]};
			enc.b1 = 8'h80 | {2'b00, cp_f[5:0]};
		end else begin
			enc.count = 2'd3;
			enc.b0 = 8'hE0 | {4'h0, cp_f[15:12]};
			enc.b1 = 8'h80 | {2'b00, cp_f[11:6]};
			enc.b2 = 8'h80 | {2'b00, cp_f[5:0]};
		end
	end

	always_comb begin
		nxt = cur;
		res = '0;
		res.status = ST_BYTE;
		case (cur.mode)
			MODE_IDLE: begin
				if (text_end || in_byte != Quote) begin
					res.count = 2'd1;
					res.status = ST_NOOPEN;
				end else begin
					nxt.mode = MODE_STR;
				end
			end
			MODE_STR: begin
				if (text_end) begin
					res.count = 2'd1;
					res.status = ST_TRUNC;
				end else if (in_byte == Quote) begin
					res.count = 2'd1;
					res.status = ST_DONE;
				end else if (in_byte == Bslash) begin
					nxt.mode = MODE_ESC;
				end else if (in_byte < 8'h20) begin
					res.count = 2'd1;
					res.status = ST_CTRL;
				end else begin
					res.count = 2'd1;
					res.b0 = in_byte;
				end
			end
			MODE_ESC: begin
				res.count = 2'd1;
				nxt.mode = MODE_STR;
				if (text_end) begin
					res.status = ST_TRUNC;
				end else begin
					case (in_byte)
						8'h22: res.b0 = 8'h22;
						8'h5C: res.b0 = 8'h5C;
						8'h2F: res.b0 = 8'h2F;
						8'h62: res.b0 = 8'h08;
						8'h66: res.b0 = 8'h0C;
						8'h6E: res.b0 = 8'h0A;
						8'h72: res.b0 = 8'h0D;
						8'h74: res.b0 = 8'h09;
						8'h75: begin
							res.count = 2'd0;
							nxt.mode = MODE_HEX;
							nxt.hex_count = 2'd0;
							nxt.code_partial = 12'd0;
						end
						default: res.status = ST_BADESC;
					endcase
				end
			end
			default: begin
				if (text_end) begin
					res.count = 2'd1;
					res.status = ST_TRUNC;
				end else if (!is_hex) begin
					res.count = 2'd1;
					res.status = ST_BADHEX;
				end else if (cur.hex_count != 2'd3) begin
					nxt.code_partial = {cur.code_partial[7:0], digit};
					nxt.hex_count = cur.hex_count + 2'd1;
				end else begin
					res = enc;
					nxt.mode = MODE_STR;
					nxt.hex_count = 2'd0;
					nxt.code_partial = 12'd0;
				end
			end
		endcase
		// errors and done drop back to idle with the counters cleared
		if (res.count != 2'd0 && res.status != ST_BYTE) begin
			nxt = '0;
			nxt.mode = MODE_IDLE;
		end
	end

endmodule

// File: hw/rtl/jsu_out_buf.sv
module jsu_out_buf import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       last
);

	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic [2:0] status_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic [7:0] b2_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign last = (idx_q == cnt_q - 2'd1);
	assign pop = out_valid && !out_stall;
	// room for a new group once the final word of this one leaves
	assign free = !out_valid || (pop && last);
	assign status = status_q;

	always_comb begin
		case (idx_q)
			2'd0: out_byte = b0_q;
			2'd1: out_byte = b1_q;
			default: out_byte = b2_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (last) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= res.status;
			b0_q <= res.b0;
			b1_q <= res.b1;
			b2_q <= res.b2;
		end
	end

endmodule

// File: hw/rtl/json_string_unescape_core.sv
// Result words are offered from the output register once their input word has
// passed the input register; a busy output register holds that word there.
// Throughput: one input word per cycle while the output is not stalled; a \u escape
// that encodes to two or three UTF-8 bytes holds the input while its bytes go out,
// since the output register hands out one word per cycle when not stalled.
// Reset: arst_n clears the scan state to idle and empties both registers.
`include "json_string_unescape_core_defines.svh"
module json_string_unescape_core import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       text_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	scan_state_t state_q;
	scan_state_t state_nxt;
	result_t     res;
	logic        free;
	logic        move;

	assign move = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= in_byte;
			end_s1 <= text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (move) begin
			state_q <= state_nxt;
		end
	end

	jsu_decode u_decode (
		.cur      (state_q),
		.in_byte  (byte_s1),
		.text_end (end_s1),
		.nxt      (state_nxt),
		.res      (res)
	);

	jsu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (move),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.status    (status),
		.last      (last)
	);

	`JSU_ASSERT_IMPLY(a_err_is_last, out_valid && status != ST_BYTE, last)
	`JSU_ASSERT_IMPLY(a_stall_needs_word, in_stall, valid_s1 && out_valid)
	`JSU_ASSERT_IMPLY(a_hex_count_mode, state_q.hex_count != 2'd0, state_q.mode == MODE_HEX)
	`JSU_ASSERT_NEXT(a_fault_to_idle, move && res.count != 2'd0 && res.status != ST_BYTE,
		state_q.mode == MODE_IDLE)

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
module tb;
	import jsu_pkg::*;

	localparam int RANDOM_WORDS = 500;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CALM_START = 300;
	localparam int CALM_LEN = 300;
	localparam int HOLD_AFTER = 200;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 16;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       typed;
		logic [7:0] t_byte;
		logic [2:0] t_status;
	} text_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] status;
		logic       last;
	} out_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       text_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic [2:0] status;
	logic       last;

	json_string_unescape_core DUT (.*);

	text_word_t send_q[$];
	text_word_t cur_word;
	out_word_t  unescaped_q[$];
	out_word_t  fresh[$];
	int         cyc = 0;
	int         words_taken = 0;
	bit         failed = 1'b0;

	// scanner state mirrored from the block
	mode_t       scan_mode = MODE_IDLE;
	logic [1:0]  hex_taken = '0;
	logic [11:0] code_acc = '0;

	logic [7:0] short_esc [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

	// typed rows carry their single expected word; the rest go through the predictor
	text_word_t directed_rows [29] = '{
		'{8'h41, 1'b0, 1'b1, 8'h00, ST_NOOPEN},
		'{8'h22, 1'b1, 1'b1, 8'h00, ST_NOOPEN},
		'{8'h22, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'hFF, 1'b0, 1'b1, 8'hFF, ST_BYTE},
		'{8'h20, 1'b0, 1'b1, 8'h20, ST_BYTE},
		'{8'h5C, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h75, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h44, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h38, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h66, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h46, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h5C, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h75, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h30, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h30, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h30, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h30, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h1F, 1'b0, 1'b1, 8'h00, ST_CTRL},
		'{8'h22, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h5C, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h78, 1'b0, 1'b1, 8'h00, ST_BADESC},
		'{8'h22, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h5C, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h75, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h67, 1'b0, 1'b1, 8'h00, ST_BADHEX},
		'{8'h22, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h22, 1'b0, 1'b1, 8'h00, ST_DONE},
		'{8'h22, 1'b0, 1'b0, 8'h00, ST_BYTE},
		'{8'h00, 1'b1, 1'b1, 8'h00, ST_TRUNC}
	};

	function automatic void push_word(logic [7:0] c, logic [2:0] st);
		fresh.push_back('{c, st, 1'b0});
	endfunction

	function automatic void close_string(logic [2:0] st);
		scan_mode = MODE_IDLE;
		hex_taken = '0;
		code_acc = '0;
		push_word(8'h00, st);
	endfunction

	function automatic int hex_value(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	// work out the words that one accepted input word causes
	function automatic void unescape_word(logic [7:0] c, logic eot);
		logic [7:0]  esc;
		logic        known;
		logic [15:0] cp;
		int          d;
		fresh.delete();
		case (scan_mode)
			MODE_IDLE: begin
				if (eot || c != CH_QUOTE)
					close_string(ST_NOOPEN);
				else
					scan_mode = MODE_STR;
			end
			MODE_STR: begin
				if (eot)
					close_string(ST_TRUNC);
				else if (c == CH_QUOTE)
					close_string(ST_DONE);
				else if (c == CH_BSLASH)
					scan_mode = MODE_ESC;
				else if (c < CH_SPACE)
					close_string(ST_CTRL);
				else
					push_word(c, ST_BYTE);
			end
			MODE_ESC: begin
				known = 1'b1;
				esc = c;
				if (eot) begin
					close_string(ST_TRUNC);
				end else if (c == CH_U) begin
					scan_mode = MODE_HEX;
					hex_taken = '0;
					code_acc = '0;
				end else begin
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: esc = c;
						8'h62: esc = 8'h08;
						8'h66: esc = 8'h0C;
						8'h6E: esc = 8'h0A;
						8'h72: esc = 8'h0D;
						8'h74: esc = 8'h09;
						default: known = 1'b0;
					endcase
					if (known) begin
						scan_mode = MODE_STR;
						push_word(esc, ST_BYTE);
					end else begin
						close_string(ST_BADESC);
					end
				end
			end
			default: begin
				d = hex_value(c);
				if (eot) begin
					close_string(ST_TRUNC);
				end else if (d < 0) begin
					close_string(ST_BADHEX);
				end else if (hex_taken < 2'd3) begin
					code_acc = {code_acc[7:0], d[3:0]};
					hex_taken = hex_taken + 2'd1;
				end else begin
					cp = {code_acc, d[3:0]};
					scan_mode = MODE_STR;
					hex_taken = '0;
					code_acc = '0;
					// surrogates are never paired, each becomes U+FFFD
					if (cp >= 16'hD800 && cp <= 16'hDFFF)
						cp = 16'hFFFD;
					if (cp < 16'h0080) begin
						push_word(cp[7:0], ST_BYTE);
					end else if (cp < 16'h0800) begin
						push_word({3'b110, cp[10:6]}, ST_BYTE);
						push_word({2'b10, cp[5:0]}, ST_BYTE);
					end else begin
						push_word({4'b1110, cp[15:12]}, ST_BYTE);
						push_word({2'b10, cp[11:6]}, ST_BYTE);
						push_word({2'b10, cp[5:0]}, ST_BYTE);
					end
				end
			end
		endcase
	endfunction

	function automatic void add_word(logic [7:0] c, logic eot);
		send_q.push_back('{c, eot, 1'b0, 8'h00, ST_BYTE});
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + n;
		return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	// plain bytes, short escapes and \u escapes of every UTF-8 length
	function automatic void add_string_body(int parts);
		logic [15:0] cp;
		logic [7:0]  c;
		repeat (parts) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					do c = 8'($urandom_range(8'h20, 8'hFF));
					while (c == CH_QUOTE || c == CH_BSLASH);
					add_word(c, 1'b0);
				end
				5, 6: begin
					add_word(CH_BSLASH, 1'b0);
					add_word(short_esc[3'($urandom_range(7))], 1'b0);
				end
				default: begin
					case ($urandom_range(3))
						0: cp = 16'($urandom_range(16'h007F));
						1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
						2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
						default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
					endcase
					add_word(CH_BSLASH, 1'b0);
					add_word(CH_U, 1'b0);
					for (int k = 3; k >= 0; k--)
						add_word(hex_char(cp[k*4 +: 4]), 1'b0);
				end
			endcase
		end
	endfunction

	function automatic bit take_break();
		if (cyc >= CALM_START && cyc < CALM_START + CALM_LEN)
			return 1'b0;
		return $urandom_range(99) < 38;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int kind;
		arst_n <= 1'b0;
		foreach (directed_rows[i])
			send_q.push_back(directed_rows[i]);
		while (send_q.size() < $size(directed_rows) + RANDOM_WORDS) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				add_word(CH_QUOTE, 1'b0);
				add_string_body($urandom_range(8));
				add_word(CH_QUOTE, 1'b0);
			end else if (kind < 87) begin
				// cut the text inside the string, an escape or a hex run
				add_word(CH_QUOTE, 1'b0);
				add_string_body($urandom_range(3));
				case ($urandom_range(2))
					0: add_word(CH_BSLASH, 1'b0);
					1: begin
						add_word(CH_BSLASH, 1'b0);
						add_word(CH_U, 1'b0);
						repeat ($urandom_range(3))
							add_word(hex_char(4'($urandom_range(15))), 1'b0);
					end
					default: ;
				endcase
				add_word(8'($urandom_range(255)), 1'b1);
			end else if (kind < 95) begin
				add_word(CH_QUOTE, 1'b0);
				add_string_body($urandom_range(3));
				case ($urandom_range(2))
					0: begin
						add_word(CH_BSLASH, 1'b0);
						add_word(8'($urandom_range(255)), 1'b0);
					end
					1: begin
						add_word(CH_BSLASH, 1'b0);
						add_word(CH_U, 1'b0);
						repeat ($urandom_range(3))
							add_word(hex_char(4'($urandom_range(15))), 1'b0);
						add_word(8'($urandom_range(255)), 1'b0);
					end
					default: add_word(8'($urandom_range(8'h1F)), 1'b0);
				endcase
			end else begin
				repeat ($urandom_range(1, 4))
					add_word(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk);
		while (send_q.size() != 0 || unescaped_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		text_end <= 1'b0;
		cur_word <= '0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall)
				void'(send_q.pop_front());
			// hold a stalled word as it is
			if (!(in_valid && in_stall)) begin
				if (send_q.size() != 0 && !take_break()) begin
					in_valid <= 1'b1;
					in_byte <= send_q[0].ch;
					text_end <= send_q[0].eot;
					cur_word <= send_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			// back up the block long enough that it stalls its input
			if (!held && words_taken >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= take_break();
			end
		end
	end

	always @(posedge clk) begin : monitor
		out_word_t want;
		cyc <= cyc + 1;
		if (in_valid && !in_stall) begin
			unescape_word(cur_word.ch, cur_word.eot);
			if (cur_word.typed) begin
				fresh.delete();
				push_word(cur_word.t_byte, cur_word.t_status);
			end
			if (fresh.size() != 0)
				fresh[fresh.size() - 1].last = 1'b1;
			foreach (fresh[i])
				unescaped_q.push_back(fresh[i]);
			words_taken <= words_taken + 1;
		end
		if (out_valid && !out_stall) begin
			if (unescaped_q.size() == 0) begin
				$error("unexpected word: out_byte %h status %0d last %0b",
					out_byte, status, last);
				failed = 1'b1;
			end else begin
				want = unescaped_q.pop_front();
				if (out_byte !== want.ch) begin
					$error("out_byte: expected %h, got %h", want.ch, out_byte);
					failed = 1'b1;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failed = 1'b1;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		wait (cyc >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule
